/* design/dqi_pkg.sv */
`default_nettype none

package dqi_pkg;

    localparam int unsigned DEFAULT_DEPTH = 16;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned KIND_W        = 3;
    localparam int unsigned POS_W         = 5;
    localparam int unsigned COUNT_W       = 5;
    localparam int unsigned STATUS_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_INSERT     = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [COUNT_W-1:0]       count;
    } t_out_word;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              shift_in;
        logic              shift_out;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* design/dqi_cell.sv */
`default_nettype none

module dqi_cell
    import dqi_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 5
) (
    input  wire logic              i_clk,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [CW-1:0]     i_pos,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    input  wire logic [CW-1:0]     i_last_idx,
    output logic [DATA_W-1:0]      o_data,
    output logic [DATA_W-1:0]      o_back
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              at_pos;
    logic              past_pos;

    assign at_pos   = (MY_IDX == i_pos);
    assign past_pos = (MY_IDX > i_pos);

    always_comb begin
        n_data = r_data;
        if (i_cmd.shift_in) begin
            if (at_pos) begin
                n_data = i_cmd.value;
            end else if (past_pos) begin
                n_data = i_left;
            end
        end else if (i_cmd.shift_out) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_back = (MY_IDX == i_last_idx) ? r_data : '0;

endmodule

`default_nettype wire

/* design/bounded_deque_with_insert_unit.sv */
`default_nettype none

// bounded deque with positional insert, built as a row of register cells
// input channel (i_in_valid / o_in_ready / i_in_data) takes one word per
// operation: push front, push back, pop front, pop back or insert before a
// position; output channel (o_out_valid / i_out_ready / o_out_data) returns
// one word per operation with status, front and back values and count
// an accepted operation updates the affected cells at once on the accepting edge;
// the result word is formed from the updated cells once the output register is
// free, and stays in the output register until taken
// a new word is not accepted until the result of the previous one is formed
// while a result waits, the next word is still accepted; its own result is
// held back until the output register is free, and input stays stalled then
// reset (i_rst_n low at a clock edge) empties the store and drops any result
// cell contents are not cleared; an empty store reports -1 for both ends
module bounded_deque_with_insert_unit
    import dqi_pkg::*;
#(
    parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in_word i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_word o_out_data
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic              r_busy;
    logic              r_out_valid;
    t_out_word         r_out;
    t_status           r_status;
    logic [CW-1:0]     r_count;

    logic              in_acc;
    logic              out_free;
    t_cell_cmd         cmd;
    logic [CW-1:0]     cmd_pos;
    t_status           n_status;
    logic [CW-1:0]     n_count;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic              is_full;
    logic              is_empty;
    logic [CW-1:0]     last_idx;
    logic [DATA_W-1:0] back_or;
    logic [DATA_W-1:0] front_val;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_back [DEPTH];

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && !r_busy;
    assign out_free   = !r_out_valid || i_out_ready;

    assign pos_ext  = PW'(i_in_data.position);
    assign cnt_ext  = PW'(r_count);
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    // decode the operation against the current count
    always_comb begin
        cmd       = '0;
        cmd.value = i_in_data.value;
        cmd_pos   = '0;
        n_status  = ST_OK;
        n_count   = r_count;
        case (i_in_data.kind)
            KIND_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.shift_in = 1'b1;
                    cmd_pos      = '0;
                    n_count      = r_count + 1'b1;
                end
            end
            KIND_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.shift_in = 1'b1;
                    cmd_pos      = r_count;
                    n_count      = r_count + 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    cmd.shift_out = 1'b1;
                    n_count       = r_count - 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            KIND_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    n_status = ST_BADPOS;
                end else if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.shift_in = 1'b1;
                    cmd_pos      = CW'(pos_ext);
                    n_count      = r_count + 1'b1;
                end
            end
            default: begin
                n_status = ST_BADPOS;
            end
        endcase
        if (!in_acc) begin
            cmd.shift_in  = 1'b0;
            cmd.shift_out = 1'b0;
        end
    end

    assign last_idx = r_count - 1'b1;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = cmd.value;
        end else begin : g_mid
            assign left_w = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_inner
            assign right_w = cell_data[g+1];
        end
        dqi_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_pos      (cmd_pos),
            .i_left     (left_w),
            .i_right    (right_w),
            .i_last_idx (last_idx),
            .o_data     (cell_data[g]),
            .o_back     (cell_back[g])
        );
    end

    // only the last occupied cell drives a nonzero back word
    always_comb begin
        back_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_or = back_or | cell_back[k];
        end
    end

    assign front_val = cell_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_status    <= ST_OK;
        end else begin
            if (r_busy && out_free) begin
                r_busy             <= 1'b0;
                r_out_valid        <= 1'b1;
                r_out.status       <= r_status;
                r_out.count        <= COUNT_W'(r_count);
                r_out.front_value  <= is_empty ? '1 : front_val;
                r_out.back_value   <= is_empty ? '1 : back_or;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_busy   <= 1'b1;
                r_status <= n_status;
                r_count  <= n_count;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
